### hdl/rn_pkg.sv
// Package for the integer to Roman numeral converter.
// Holds the queue item type, the front-end state type, the ASCII symbol codes
// and the digit helper functions. Depends on nothing.
`default_nettype none

package rn_pkg;

  // Largest value that has a numeral
  localparam logic [11:0] VALUE_MAX = 12'd3999;

  // ASCII codes of the numeral symbols
  localparam logic [6:0] SYM_NONE = 7'h00;
  localparam logic [6:0] SYM_I    = 7'h49;
  localparam logic [6:0] SYM_V    = 7'h56;
  localparam logic [6:0] SYM_X    = 7'h58;
  localparam logic [6:0] SYM_L    = 7'h4C;
  localparam logic [6:0] SYM_C    = 7'h43;
  localparam logic [6:0] SYM_D    = 7'h44;
  localparam logic [6:0] SYM_M    = 7'h4D;

  // Decimal places, most significant first
  localparam logic [1:0] POS_THOUSANDS = 2'd3;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_UNITS     = 2'd0;

  // One classified number on its way from front to back
  typedef struct packed {
    logic            err;    // zero or above the numeral range
    logic [3:0][3:0] digit;  // decimal digits, index = place
  } rn_item_t;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } rn_front_state_t;

  // d times the weight of decimal place pos
  function automatic logic [13:0] step_value(input logic [1:0] pos, input logic [3:0] d);
    logic [13:0] place;
    case (pos)
      POS_THOUSANDS: place = 14'd1000;
      POS_HUNDREDS:  place = 14'd100;
      POS_TENS:      place = 14'd10;
      default:       place = 14'd1;
    endcase
    return 14'(place * {10'd0, d});
  endfunction

  // Number of characters that one digit spells
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    case (d)
      4'd1, 4'd5:             return 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: return 3'd2;
      4'd3, 4'd7:             return 3'd3;
      4'd8:                   return 3'd4;
      default:                return 3'd0;
    endcase
  endfunction

  // Character k of digit d at place pos
  function automatic logic [6:0] digit_sym(input logic [1:0] pos, input logic [3:0] d,
                                           input logic [1:0] k);
    logic [6:0] one;
    logic [6:0] five;
    logic [6:0] ten;
    case (pos)
      POS_THOUSANDS: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
      POS_HUNDREDS:  begin one = SYM_C; five = SYM_D; ten = SYM_M; end
      POS_TENS:      begin one = SYM_X; five = SYM_L; ten = SYM_C; end
      default:       begin one = SYM_I; five = SYM_V; ten = SYM_X; end
    endcase
    if (d == 4'd9) begin
      return (k == 2'd0) ? one : ten;
    end else if (d == 4'd4) begin
      return (k == 2'd0) ? one : five;
    end else if (d >= 4'd5) begin
      return (k == 2'd0) ? five : one;
    end else begin
      return one;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/rn_front.sv
// Front end: accepts a number, flags out-of-range values and splits the rest
// into decimal digits, one place per cycle. Depends on rn_pkg.
`default_nettype none

module rn_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire logic [11:0]    value,
  output logic                push,
  output rn_pkg::rn_item_t    push_item,
  input  wire logic           full
);
  import rn_pkg::*;

  rn_front_state_t state;
  rn_front_state_t state_next;
  logic [11:0]     rem;
  logic [1:0]      pos;
  rn_item_t        item;

  logic [3:0]      dig;
  logic [11:0]     rem_sub;
  logic            range_err;

  assign range_err = (value == 12'd0) || (value > VALUE_MAX);

  // Digit at the current place: largest d with d * weight <= remainder
  always_comb begin
    dig = 4'd0;
    for (int d = 1; d < 10; d++) begin
      if ({2'b00, rem} >= step_value(pos, 4'(d))) dig = 4'(d);
    end
    rem_sub = 12'({2'b00, rem} - step_value(pos, dig));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (item_valid) state_next = range_err ? F_PUSH : F_CONV;
      F_CONV: if (pos == POS_UNITS) state_next = F_PUSH;
      F_PUSH: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_stall = rst || (state != F_IDLE);
    push       = (state == F_PUSH) && !full;
    push_item  = item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == F_IDLE && item_valid) begin
      rem      <= value;
      pos      <= POS_THOUSANDS;
      item.err <= range_err;
    end else if (state == F_CONV) begin
      item.digit[pos] <= dig;
      rem             <= rem_sub;
      pos             <= pos - 2'd1;
    end
  end

endmodule

`default_nettype wire

### hdl/rn_fifo.sv
// Short queue of classified items between front and back ends.
// Depends on rn_pkg.
`default_nettype none

module rn_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rn_pkg::rn_item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output rn_pkg::rn_item_t    head,
  output logic                empty
);
  import rn_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rn_item_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/rn_back.sv
// Back end: spells the digits of one queued item as numeral characters,
// one per cycle unless the output stalls, into the output register. Depends on rn_pkg.
`default_nettype none

module rn_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rn_pkg::rn_item_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                char_valid,
  input  wire logic           char_stall,
  output logic [6:0]          symbol,
  output logic                last,
  output logic                out_of_range
);
  import rn_pkg::*;

  logic       active;
  rn_item_t   cur;
  logic [1:0] pos;
  logic [1:0] k;

  logic [3:0] d_cur;
  logic       at_end;
  logic       has_lower;
  logic [1:0] lower_pos;
  logic [1:0] head_pos;
  logic       is_last;
  logic       can_load;
  logic       emit;
  logic       finish;
  logic [6:0] sym_next;

  // Where the current character stands and what follows it
  always_comb begin
    d_cur     = cur.digit[pos];
    at_end    = ({1'b0, k} + 3'd1) == digit_len(d_cur);
    has_lower = 1'b0;
    lower_pos = POS_UNITS;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < pos && cur.digit[i] != 4'd0) begin
        has_lower = 1'b1;
        lower_pos = 2'(i);
      end
    end
    head_pos = POS_UNITS;
    for (int i = 0; i < 4; i++) begin
      if (head.digit[i] != 4'd0) head_pos = 2'(i);
    end
    is_last  = cur.err || (at_end && !has_lower);
    sym_next = cur.err ? SYM_NONE : digit_sym(pos, d_cur, k);
  end

  // Handshake with the output register and the queue
  assign can_load = !char_valid || !char_stall;
  assign emit     = active && can_load;
  assign finish   = emit && is_last;
  assign pop      = !empty && (!active || finish);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (pop)         active <= 1'b1;
      else if (finish) active <= 1'b0;
      if (emit)            char_valid <= 1'b1;
      else if (!char_stall) char_valid <= 1'b0;
    end
  end

  // Digit walk: start at the highest nonzero place, skip zero places
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      pos <= head_pos;
      k   <= 2'd0;
    end else if (emit && !is_last) begin
      if (at_end) begin
        pos <= lower_pos;
        k   <= 2'd0;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      symbol       <= sym_next;
      last         <= is_last;
      out_of_range <= cur.err;
    end
  end

endmodule

`default_nettype wire

### hdl/integer_to_roman_numerals.sv
// Integer to Roman numeral converter, top level.
// Joins rn_front, rn_fifo and rn_back. Depends on rn_pkg.
//
// Input channel (item_valid / item_stall / value): one 12-bit number per item.
// Output channel (char_valid / char_stall / symbol, last, out_of_range): the
// numeral as ASCII characters, most significant first, one item per char;
// last marks the final character. A value of 0 or above 3999 gives a single
// item with out_of_range = 1, last = 1 and symbol = 0.
// Throughput: the front end splits digits one place per cycle (an out-of-range
// number skips the split) and takes a new number only once the last one is
// pushed into the queue; the back end sends one character per cycle while the
// output is not stalled, 1 to 15 characters per number.
// The queue of QUEUE_DEPTH items (at least 2) lets the front end convert
// ahead while the back end is still spelling or the receiver stalls.
// A stalled character holds in the output register; the back end and then
// the queue and front end wait behind it.
// Reset (rst, synchronous) empties the queue and output register and holds
// item_stall high; no state is kept between numbers.
`default_nettype none

module integer_to_roman_numerals #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [11:0] value,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [6:0]       symbol,
  output logic             last,
  output logic             out_of_range
);
  import rn_pkg::*;

  logic     push;
  rn_item_t push_item;
  logic     full;
  logic     pop;
  rn_item_t head;
  logic     empty;

  rn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  rn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  rn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .symbol       (symbol),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

### hdl/rn_checker.sv
// Port-level checks for the Roman numeral converter, bound to the top level.
// Depends on rn_pkg.
`default_nettype none

module rn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic [11:0] value,
  input wire logic        char_valid,
  input wire logic        char_stall,
  input wire logic [6:0]  symbol,
  input wire logic        last,
  input wire logic        out_of_range
);
  import rn_pkg::*;

  // Nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("output valid right after reset");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_stall) |=> (item_valid && $stable(value)))
    else $error("stalled input changed");

  // Error item is a single, empty character
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (char_valid && out_of_range) |-> (last && symbol == SYM_NONE))
    else $error("error item is not a single empty character");

  // Normal characters are numeral symbols only
  a_sym_legal: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !out_of_range) |->
      (symbol == SYM_I || symbol == SYM_V || symbol == SYM_X || symbol == SYM_L ||
       symbol == SYM_C || symbol == SYM_D || symbol == SYM_M))
    else $error("character is not a numeral symbol");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=>
      (char_valid && $stable(symbol) && $stable(last) && $stable(out_of_range)))
    else $error("stalled output changed");

endmodule

bind integer_to_roman_numerals rn_checker u_rn_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .value        (value),
  .char_valid   (char_valid),
  .char_stall   (char_stall),
  .symbol       (symbol),
  .last         (last),
  .out_of_range (out_of_range)
);

`default_nettype wire
